// ===== design/delta_frame_rle_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// delta_frame_rle_decoder_macros.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef DELTA_FRAME_RLE_DECODER_MACROS_SVH
`define DELTA_FRAME_RLE_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DFRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define DFRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is checked through reset
`define DFRD_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dfrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfrd_pkg
// types, widths and codes of the delta frame run-length decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfrd_pkg;

   localparam int ADDR_BITS    = 20;
   localparam int CURSOR_W     = ADDR_BITS + 1;
   localparam int AMOUNT_W     = 16;
   localparam int SUM_W        = ((CURSOR_W > AMOUNT_W) ? CURSOR_W : AMOUNT_W) + 1;
   localparam int FRAME_SIZE_W = 21;
   localparam int OVF_W        = ((CURSOR_W > FRAME_SIZE_W) ? CURSOR_W : FRAME_SIZE_W) + 1;
   localparam int DELTA_W      = 16;
   localparam int PIX_ADDR_W   = 20;
   localparam int RUN_W        = 14;
   localparam int BYTE_W       = 8;
   localparam int LIT_W        = 7;
   localparam int KIND_W       = 2;
   localparam int PHASE_W      = 3;

   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = FRAME_SIZE_W'(65536);
   localparam logic [DELTA_W-1:0]      DELTA_RESET      = '0;

   localparam logic [BYTE_W-1:0] CODE_WORD    = 8'h80;
   localparam logic [BYTE_W-1:0] CODE_LIT_MAX = 8'h7F;
   localparam int                WORD_FLAG    = 15;
   localparam logic [15:0]       WORD_COUNT   = 16'h3FFF;

   // register indexes
   localparam logic REG_FRAME_SIZE   = 1'b0;
   localparam logic REG_DELTA_FRAMES = 1'b1;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_CODE       = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ZERO_NEXT  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_FILL_VALUE = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LITERAL    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_WORD_LO    = 3'd4;
   localparam logic [PHASE_W-1:0] PH_WORD_HI    = 3'd5;
   localparam logic [PHASE_W-1:0] PH_ZERO_CHECK = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FILL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STREAM  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CURSOR_W-1:0] cursor;
      logic [RUN_W-1:0]    run_length;
      logic [BYTE_W-1:0]   pixel_value;
      logic [DELTA_W-1:0]  frame_index;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic [FRAME_SIZE_W-1:0] frame_size;
      logic [DELTA_W-1:0]      delta_frames;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/delta_frame_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// delta_frame_rle_decoder
// turns a delta-coded animation byte stream into frame-buffer write commands
// ----------------------------------------------------------------------------
// One encoded byte is taken per clock; a parse step never stalls the input by
// itself, only a full command queue does. A byte that produces a result reaches
// the rsp_ ports through the queue: the parser writes its command into the
// queue at the accepting edge, and the result register, which sits behind the
// overflow compare, loads it from the queue head when that register is empty or
// being popped. The four-entry queue between parser and result register absorbs
// short rsp_pop stalls. Write frame_size and delta_frames while the block is
// idle; raise stream_start with the first byte of each stream.
`timescale 1ns / 1ps
`default_nettype none

module delta_frame_rle_decoder
   import dfrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [BYTE_W-1:0]     req_code_byte,
   input  wire logic                  req_stream_start,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic      [KIND_W-1:0]     rsp_kind,
   output logic      [PIX_ADDR_W-1:0] rsp_pixel_address,
   output logic      [RUN_W-1:0]      rsp_run_length,
   output logic      [BYTE_W-1:0]     rsp_pixel_value,
   output logic      [DELTA_W-1:0]    rsp_frame_index,
   output logic                       rsp_overflow,
   output logic                       rsp_last,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;
   cmd_type cmd;
   cmd_type head_cmd;
   logic    cmd_valid;
   logic    accept;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_pop;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   dfrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dfrd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .code_byte    (req_code_byte),
      .stream_start (req_stream_start),
      .delta_frames (cfg.delta_frames),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd)
   );

   dfrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   dfrd_result u_result (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .queue_empty       (queue_empty),
      .queue_pop         (queue_pop),
      .frame_size        (cfg.frame_size),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_run_length    (rsp_run_length),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== design/dfrd_csr.sv =====
// ----------------------------------------------------------------------------
// dfrd_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrd_csr
   import dfrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [FRAME_SIZE_W-1:0] frame_size_ff, frame_size_in;
   logic [DELTA_W-1:0]      delta_frames_ff, delta_frames_in;
   logic                    wr_en;
   logic                    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_comb begin
      frame_size_in   = frame_size_ff;
      delta_frames_in = delta_frames_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FRAME_SIZE:   frame_size_in   = pwdata[FRAME_SIZE_W-1:0];
            REG_DELTA_FRAMES: delta_frames_in = pwdata[DELTA_W-1:0];
            default:          frame_size_in   = frame_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff   <= FRAME_SIZE_RESET;
         delta_frames_ff <= DELTA_RESET;
      end else begin
         frame_size_ff   <= frame_size_in;
         delta_frames_ff <= delta_frames_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FRAME_SIZE:   prdata = CSR_DATA_W'(frame_size_ff);
         REG_DELTA_FRAMES: prdata = CSR_DATA_W'(delta_frames_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.frame_size   = frame_size_ff;
   assign cfg.delta_frames = delta_frames_ff;

endmodule

`default_nettype wire

// ===== design/dfrd_parser.sv =====
// ----------------------------------------------------------------------------
// dfrd_parser
// front end: parses one stream byte per beat and tracks the frame cursor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrd_parser
   import dfrd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [BYTE_W-1:0]  code_byte,
   input  wire logic               stream_start,
   input  wire logic [DELTA_W-1:0] delta_frames,
   output logic                    cmd_valid,
   output cmd_type                 cmd
);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [CURSOR_W-1:0] pend_ff, pend_in;
   logic [LIT_W-1:0]    lit_ff, lit_in;
   logic [BYTE_W-1:0]   rc_ff, rc_in;
   logic [BYTE_W-1:0]   wl_ff, wl_in;
   logic [RUN_W-1:0]    pz_ff, pz_in;
   logic [DELTA_W-1:0]  fd_ff, fd_in;
   logic                fin_ff, fin_in;

   logic [PHASE_W-1:0]  ph_eff;
   logic [CURSOR_W-1:0] cur_eff;
   logic [DELTA_W-1:0]  fd_eff;
   logic [DELTA_W-1:0]  fd_next;
   logic                fin_eff;
   logic                no_frames;
   logic                skip_code;
   logic [15:0]         word;
   logic [CURSOR_W-1:0] base;
   logic [AMOUNT_W-1:0] amount;
   logic [SUM_W-1:0]    sum;
   logic [CURSOR_W-1:0] adv;
   logic [LIT_W-1:0]    lit_dec;

   assign ph_eff    = stream_start ? PH_CODE : phase_ff;
   assign cur_eff   = stream_start ? '0 : cursor_ff;
   assign fd_eff    = stream_start ? '0 : fd_ff;
   assign fin_eff   = stream_start ? 1'b0 : fin_ff;
   assign fd_next   = fd_eff + 1'b1;
   assign no_frames = (fd_eff >= delta_frames);
   assign skip_code = (code_byte > CODE_WORD) && !no_frames;
   assign word      = {code_byte, wl_ff};
   assign lit_dec   = lit_ff - 1'b1;

   // shared cursor adder
   always_comb begin
      base   = cur_eff;
      amount = '0;
      case (ph_eff)
         PH_FILL_VALUE: amount = AMOUNT_W'(rc_ff);
         PH_LITERAL:    amount = AMOUNT_W'(1);
         PH_WORD_HI:    amount = word[WORD_FLAG] ? (word & WORD_COUNT) : word;
         PH_ZERO_NEXT,
         PH_WORD_LO:    amount = '0;
         PH_ZERO_CHECK: begin
            base   = pend_ff;
            amount = skip_code ? AMOUNT_W'(code_byte[LIT_W-1:0]) : '0;
         end
         default:       amount = skip_code ? AMOUNT_W'(code_byte[LIT_W-1:0]) : '0;
      endcase
   end

   assign sum = SUM_W'(base) + SUM_W'(amount);
   assign adv = (sum[SUM_W-1:CURSOR_W] != '0) ? {CURSOR_W{1'b1}} : sum[CURSOR_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      cursor_in = cursor_ff;
      pend_in   = pend_ff;
      lit_in    = lit_ff;
      rc_in     = rc_ff;
      wl_in     = wl_ff;
      pz_in     = pz_ff;
      fd_in     = fd_ff;
      fin_in    = fin_ff;
      cmd_valid = 1'b0;
      cmd       = '0;
      cmd.frame_index = fd_eff;
      if (accept) begin
         phase_in  = ph_eff;
         cursor_in = cur_eff;
         fd_in     = fd_eff;
         fin_in    = fin_eff;
         if (stream_start) begin
            lit_in = '0;
            rc_in  = '0;
            wl_in  = '0;
            pz_in  = '0;
         end
         if (!fin_eff) begin
            case (ph_eff)
               PH_ZERO_NEXT: begin
                  if (code_byte == '0) begin
                     phase_in  = PH_CODE;
                     fin_in    = 1'b1;
                     cmd_valid = 1'b1;
                     cmd.kind  = KIND_STREAM;
                     cmd.last  = 1'b1;
                  end else begin
                     rc_in    = code_byte;
                     phase_in = PH_FILL_VALUE;
                  end
               end
               PH_FILL_VALUE: begin
                  cmd_valid       = 1'b1;
                  cmd.kind        = KIND_FILL;
                  cmd.cursor      = cur_eff;
                  cmd.run_length  = RUN_W'(rc_ff);
                  cmd.pixel_value = code_byte;
                  cursor_in       = adv;
                  phase_in        = PH_CODE;
               end
               PH_LITERAL: begin
                  cmd_valid       = 1'b1;
                  cmd.kind        = KIND_LITERAL;
                  cmd.cursor      = cur_eff;
                  cmd.run_length  = RUN_W'(1);
                  cmd.pixel_value = code_byte;
                  cursor_in       = adv;
                  lit_in          = lit_dec;
                  if (lit_dec == '0) begin
                     phase_in = PH_CODE;
                  end
               end
               PH_WORD_LO: begin
                  wl_in    = code_byte;
                  phase_in = PH_WORD_HI;
               end
               PH_WORD_HI: begin
                  phase_in = PH_CODE;
                  if (word == '0) begin
                     cmd_valid = 1'b1;
                     cmd.kind  = KIND_FRAME;
                     cmd.last  = (fd_next >= delta_frames);
                     fd_in     = fd_next;
                     cursor_in = '0;
                     if (fd_next >= delta_frames) begin
                        fin_in = 1'b1;
                     end
                  end else if (word[WORD_FLAG]) begin
                     pz_in    = word[RUN_W-1:0];
                     pend_in  = adv;
                     phase_in = PH_ZERO_CHECK;
                  end else begin
                     cursor_in = adv;
                  end
               end
               default: begin
                  // code byte, possibly right after a pending zero run
                  phase_in  = PH_CODE;
                  cursor_in = adv;
                  if ((ph_eff == PH_ZERO_CHECK) && (code_byte == '0)) begin
                     cmd_valid       = 1'b1;
                     cmd.kind        = KIND_FILL;
                     cmd.cursor      = cur_eff;
                     cmd.run_length  = pz_ff;
                     cmd.pixel_value = '0;
                  end else if (no_frames) begin
                     fin_in    = 1'b1;
                     cmd_valid = 1'b1;
                     cmd.kind  = KIND_STREAM;
                     cmd.last  = 1'b1;
                  end else if (code_byte == '0) begin
                     phase_in = PH_ZERO_NEXT;
                  end else if (code_byte <= CODE_LIT_MAX) begin
                     lit_in   = code_byte[LIT_W-1:0];
                     phase_in = PH_LITERAL;
                  end else if (code_byte == CODE_WORD) begin
                     phase_in = PH_WORD_LO;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CODE;
         cursor_ff <= '0;
         lit_ff    <= '0;
         rc_ff     <= '0;
         wl_ff     <= '0;
         pz_ff     <= '0;
         fd_ff     <= '0;
         fin_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cursor_ff <= cursor_in;
         lit_ff    <= lit_in;
         rc_ff     <= rc_in;
         wl_ff     <= wl_in;
         pz_ff     <= pz_in;
         fd_ff     <= fd_in;
         fin_ff    <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

// ===== design/dfrd_queue.sv =====
// ----------------------------------------------------------------------------
// dfrd_queue
// short command queue between the parser and the result stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrd_queue
   import dfrd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output cmd_type   head_cmd,
   output logic      empty
);

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/dfrd_result.sv =====
// ----------------------------------------------------------------------------
// dfrd_result
// back end: overflow check and the registered result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrd_result
   import dfrd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  cmd_type                      head_cmd,
   input  wire logic                    queue_empty,
   output logic                         queue_pop,
   input  wire logic [FRAME_SIZE_W-1:0] frame_size,
   input  wire logic                    rsp_pop,
   output logic                         rsp_empty,
   output logic      [KIND_W-1:0]       rsp_kind,
   output logic      [PIX_ADDR_W-1:0]   rsp_pixel_address,
   output logic      [RUN_W-1:0]        rsp_run_length,
   output logic      [BYTE_W-1:0]       rsp_pixel_value,
   output logic      [DELTA_W-1:0]      rsp_frame_index,
   output logic                         rsp_overflow,
   output logic                         rsp_last
);

   logic                  valid_ff, valid_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [PIX_ADDR_W-1:0] addr_ff;
   logic [RUN_W-1:0]      len_ff;
   logic [BYTE_W-1:0]     value_ff;
   logic [DELTA_W-1:0]    index_ff;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff;
   logic [OVF_W-1:0]      reach;
   logic                  load;

   assign load      = !queue_empty && (!valid_ff || rsp_pop);
   assign queue_pop = load;
   assign reach     = OVF_W'(head_cmd.cursor) + OVF_W'(head_cmd.run_length);
   assign ovf_in    = ((head_cmd.kind == KIND_LITERAL) || (head_cmd.kind == KIND_FILL))
                      && (reach > OVF_W'(frame_size));

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head_cmd.kind;
         addr_ff  <= PIX_ADDR_W'(head_cmd.cursor[ADDR_BITS-1:0]);
         len_ff   <= head_cmd.run_length;
         value_ff <= head_cmd.pixel_value;
         index_ff <= head_cmd.frame_index;
         ovf_ff   <= ovf_in;
         last_ff  <= head_cmd.last;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_run_length    = len_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_frame_index   = index_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

// ===== design/dfrd_checker.sv =====
// ----------------------------------------------------------------------------
// dfrd_checker
// port-level checks of the decoder's result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delta_frame_rle_decoder_macros.svh"

module dfrd_checker
   import dfrd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_full,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire logic [KIND_W-1:0]     rsp_kind,
   input wire logic [PIX_ADDR_W-1:0] rsp_pixel_address,
   input wire logic [RUN_W-1:0]      rsp_run_length,
   input wire logic                  rsp_overflow,
   input wire logic                  rsp_last
);

   logic marker_beat;
   logic beat_waits;

   assign marker_beat = !rsp_empty && ((rsp_kind == KIND_FRAME) || (rsp_kind == KIND_STREAM));
   assign beat_waits  = !rsp_empty && !rsp_pop;

   `DFRD_ASSERT_ALWAYS(a_reset_clears, clock, reset, rsp_empty && !req_full,
      "queue not empty after reset")

   `DFRD_ASSERT_NEXT(a_stall_holds, clock, reset, beat_waits,
      !rsp_empty && $stable(rsp_kind) && $stable(rsp_pixel_address) && $stable(rsp_last),
      "stalled result beat changed")

   `DFRD_ASSERT_NOW(a_marker_clean, clock, reset, marker_beat,
      rsp_pixel_address == '0 && rsp_run_length == '0 && !rsp_overflow,
      "frame or stream marker carries write fields")

   `DFRD_ASSERT_NOW(a_last_on_marker, clock, reset, !rsp_empty && rsp_last,
      marker_beat, "last set on a write beat")

   `DFRD_ASSERT_NOW(a_literal_one, clock, reset, !rsp_empty && rsp_kind == KIND_LITERAL,
      rsp_run_length == RUN_W'(1), "literal beat with run length other than one")

endmodule

bind delta_frame_rle_decoder dfrd_checker u_checker (.*);

`default_nettype wire

// ===== dv/delta_frame_rle_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_frame_rle_decoder_checker
// watches the byte, command and register ports of the delta frame decoder,
// decodes every accepted byte with its own parser copy and compares each
// popped command field by field with the oldest one it predicted
// ----------------------------------------------------------------------------

module delta_frame_rle_decoder_checker
   import dfrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [BYTE_W-1:0]     req_code_byte,
   input  logic                  req_stream_start,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [PIX_ADDR_W-1:0] rsp_pixel_address,
   input  logic [RUN_W-1:0]      rsp_run_length,
   input  logic [BYTE_W-1:0]     rsp_pixel_value,
   input  logic [DELTA_W-1:0]    rsp_frame_index,
   input  logic                  rsp_overflow,
   input  logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int unsigned CURSOR_TOP = (1 << CURSOR_W) - 1;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [PIX_ADDR_W-1:0] pixel_address;
      logic [RUN_W-1:0]      run_length;
      logic [BYTE_W-1:0]     pixel_value;
      logic [DELTA_W-1:0]    frame_index;
      logic                  overflow;
      logic                  is_last;
   } frame_cmd_type;

   logic [FRAME_SIZE_W-1:0] frame_size_q;
   logic [DELTA_W-1:0]      delta_frames_q;
   logic [PHASE_W-1:0]      phase;
   logic [CURSOR_W-1:0]     cursor;
   logic [LIT_W-1:0]        literal_left;
   logic [BYTE_W-1:0]       run_count;
   logic [BYTE_W-1:0]       word_low;
   logic [RUN_W-1:0]        pending_zero;
   logic [DELTA_W-1:0]      frames_done;
   logic                    finished;

   frame_cmd_type expected_cmds[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic void clear_parser();
      phase        = PH_CODE;
      cursor       = '0;
      literal_left = '0;
      run_count    = '0;
      word_low     = '0;
      pending_zero = '0;
      frames_done  = '0;
      finished     = 1'b0;
   endfunction

   function automatic void move_cursor(input int unsigned amount);
      int unsigned sum;
      sum    = cursor + amount;
      cursor = (sum > CURSOR_TOP) ? CURSOR_W'(CURSOR_TOP) : CURSOR_W'(sum);
   endfunction

   function automatic void queue_cmd(input logic [KIND_W-1:0] kind, input int unsigned len,
                                     input logic [BYTE_W-1:0] value, input logic is_last);
      frame_cmd_type cmd;
      cmd             = '0;
      cmd.kind        = kind;
      cmd.frame_index = frames_done;
      cmd.is_last     = is_last;
      if (kind == KIND_LITERAL || kind == KIND_FILL) begin
         cmd.pixel_address = cursor[PIX_ADDR_W-1:0];
         cmd.run_length    = RUN_W'(len);
         cmd.pixel_value   = value;
         cmd.overflow      = (cursor + len > frame_size_q);
      end
      expected_cmds.push_back(cmd);
   endfunction

   function automatic void decode_code(input logic [BYTE_W-1:0] code);
      if (frames_done >= delta_frames_q) begin
         finished = 1'b1;
         queue_cmd(KIND_STREAM, 0, '0, 1'b1);
      end else if (code == '0) begin
         phase = PH_ZERO_NEXT;
      end else if (code <= CODE_LIT_MAX) begin
         literal_left = code[LIT_W-1:0];
         phase        = PH_LITERAL;
      end else if (code == CODE_WORD) begin
         phase = PH_WORD_LO;
      end else begin
         move_cursor(code & CODE_LIT_MAX);
      end
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic start);
      logic [15:0]        word;
      logic [DELTA_W-1:0] next_frame;
      logic               frame_is_last;
      if (start)
         clear_parser();
      if (!finished) begin
         case (phase)
            PH_ZERO_NEXT: begin
               if (b == '0) begin
                  phase    = PH_CODE;
                  finished = 1'b1;
                  queue_cmd(KIND_STREAM, 0, '0, 1'b1);
               end else begin
                  run_count = b;
                  phase     = PH_FILL_VALUE;
               end
            end
            PH_FILL_VALUE: begin
               queue_cmd(KIND_FILL, run_count, b, 1'b0);
               move_cursor(run_count);
               phase = PH_CODE;
            end
            PH_LITERAL: begin
               queue_cmd(KIND_LITERAL, 1, b, 1'b0);
               move_cursor(1);
               literal_left = literal_left - 1'b1;
               if (literal_left == '0)
                  phase = PH_CODE;
            end
            PH_WORD_LO: begin
               word_low = b;
               phase    = PH_WORD_HI;
            end
            PH_WORD_HI: begin
               word  = {b, word_low};
               phase = PH_CODE;
               if (word == '0) begin
                  next_frame    = frames_done + 1'b1;
                  frame_is_last = (next_frame >= delta_frames_q);
                  queue_cmd(KIND_FRAME, 0, '0, frame_is_last);
                  frames_done = next_frame;
                  cursor      = '0;
                  if (frame_is_last)
                     finished = 1'b1;
               end else if (word[WORD_FLAG]) begin
                  pending_zero = RUN_W'(word & WORD_COUNT);
                  phase        = PH_ZERO_CHECK;
               end else begin
                  move_cursor(word);
               end
            end
            PH_ZERO_CHECK: begin
               phase = PH_CODE;
               move_cursor(0);
               if (b == '0) begin
                  queue_cmd(KIND_FILL, pending_zero, '0, 1'b0);
                  move_cursor(pending_zero);
               end else begin
                  // nonzero byte: the count was a skip, byte is the next code
                  move_cursor(pending_zero);
                  decode_code(b);
               end
            end
            default: begin
               phase = PH_CODE;
               decode_code(b);
            end
         endcase
      end
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   function automatic void check_result();
      frame_cmd_type want;
      if (expected_cmds.size() == 0) begin
         fail_count++;
         $display("%0t ns: beat with nothing expected, expected none, got kind %0d",
                  $time, rsp_kind);
      end else begin
         want = expected_cmds.pop_front();
         check_field("kind", want.kind, rsp_kind);
         check_field("pixel_address", want.pixel_address, rsp_pixel_address);
         check_field("run_length", want.run_length, rsp_run_length);
         check_field("pixel_value", want.pixel_value, rsp_pixel_value);
         check_field("frame_index", want.frame_index, rsp_frame_index);
         check_field("overflow", want.overflow, rsp_overflow);
         check_field("last", want.is_last, rsp_last);
      end
   endfunction

   // sampled mid-cycle, so every beat seen here is taken at the next rising edge
   always @(negedge clock) begin
      if (reset) begin
         frame_size_q   = FRAME_SIZE_RESET;
         delta_frames_q = DELTA_RESET;
         clear_parser();
         expected_cmds.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result();
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1:2] == REG_FRAME_SIZE)
               frame_size_q = pwdata[FRAME_SIZE_W-1:0];
            else if (paddr[CSR_ADDR_W-1:2] == REG_DELTA_FRAMES)
               delta_frames_q = pwdata[DELTA_W-1:0];
         end
         if (req_push && !req_full)
            decode_byte(req_code_byte, req_stream_start);
      end
      pending_count = expected_cmds.size();
   end

endmodule

// ===== dv/delta_frame_rle_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_frame_rle_decoder_tb
// drives encoded animation streams into the delta frame decoder: a short
// directed pass over every code, word form and end condition, a long receiver
// hold-off, a cursor run to saturation, then random streams under changing
// frame sizes and frame counts with random gaps on both sides
// ----------------------------------------------------------------------------

module delta_frame_rle_decoder_tb;
   import dfrd_pkg::*;

   localparam int STUCK_LIMIT     = 1000;
   localparam int RSP_HOLD_CYCLES = 100;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_BEATS    = 180;
   localparam int FRAME_SIZE_MAX  = 1048576;

   localparam logic [BYTE_W-1:0] CODE_ZERO      = 8'h00;
   localparam logic [15:0]       FRAME_END_WORD = 16'h0000;
   localparam logic [15:0]       WORD_RUN       = 16'(1 << WORD_FLAG);
   localparam logic [15:0]       WORD_SKIP_MAX  = WORD_RUN - 1'b1;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [BYTE_W-1:0]     req_code_byte;
   logic                  req_stream_start;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [KIND_W-1:0]     rsp_kind;
   logic [PIX_ADDR_W-1:0] rsp_pixel_address;
   logic [RUN_W-1:0]      rsp_run_length;
   logic [BYTE_W-1:0]     rsp_pixel_value;
   logic [DELTA_W-1:0]    rsp_frame_index;
   logic                  rsp_overflow;
   logic                  rsp_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending_count;
   int stuck_cycles = 0;
   int beats_sent;
   int frames_cfg;
   bit calm;
   bit hold_rsp;
   bit start_next;

   delta_frame_rle_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code_byte     (req_code_byte),
      .req_stream_start  (req_stream_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_run_length    (rsp_run_length),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   delta_frame_rle_decoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code_byte     (req_code_byte),
      .req_stream_start  (req_stream_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_run_length    (rsp_run_length),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 0;
      if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one byte beat; push stays high afterwards unless the next call idles
   task automatic send(input logic [BYTE_W-1:0] b, input bit counted);
      int   gap;
      logic taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_code_byte    <= b;
      req_stream_start <= start_next;
      start_next = 1'b0;
      do begin
         @(negedge clock);
         taken = !req_full;
         @(posedge clock);
      end while (!taken);
      if (counted)
         beats_sent++;
   endtask

   task automatic send_word(input logic [15:0] word);
      send(CODE_WORD, 1'b1);
      send(word[7:0], 1'b1);
      send(word[15:8], 1'b1);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end while (!done);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int unsigned fs, input int unsigned df);
      wait_idle();
      csr_write(REG_FRAME_SIZE, fs);
      csr_write(REG_DELTA_FRAMES, df);
      frames_cfg = df;
   endtask

   task automatic send_op();
      int          pick;
      int          n;
      logic [15:0] word;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
         send(BYTE_W'(n), 1'b1);
         repeat (n) send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 40) begin
         send(CODE_ZERO, 1'b1);
         send(BYTE_W'($urandom_range(1, 255)), 1'b1);
         send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 52) begin
         send(BYTE_W'($urandom_range(CODE_WORD + 1, 255)), 1'b1);
      end else if (pick < 64) begin
         word = 16'($urandom_range(0, 1) ? $urandom_range(1, 255)
                                         : $urandom_range(1, WORD_SKIP_MAX));
         send_word(word);
      end else if (pick < 78) begin
         word = WORD_RUN | 16'($urandom_range(0, WORD_SKIP_MAX));
         send_word(word);
         send(CODE_ZERO, 1'b1);
      end else if (pick < 90) begin
         // flagged word turned into a skip by the code byte after it
         word = WORD_RUN | 16'($urandom_range(0, WORD_SKIP_MAX));
         send_word(word);
         send(BYTE_W'($urandom_range(CODE_WORD + 1, 255)), 1'b1);
      end else begin
         send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic send_stream();
      int frames;
      int nops;
      int cut_at;
      int op_index;
      bit aborted;
      frames = $urandom_range(1, 3);
      if (frames > frames_cfg)
         frames = frames_cfg;
      cut_at     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : -1;
      op_index   = 0;
      aborted    = 1'b0;
      start_next = 1'b1;
      if (frames == 0)
         send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      for (int f = 0; f < frames && !aborted; f++) begin
         nops = $urandom_range(1, 6);
         for (int k = 0; k < nops && !aborted; k++) begin
            if (op_index == cut_at) begin
               // broken stream: word code left hanging, next stream restarts
               send(CODE_WORD, 1'b1);
               aborted = 1'b1;
            end else begin
               send_op();
            end
            op_index++;
         end
         if (!aborted)
            send_word(FRAME_END_WORD);
      end
      if (!aborted && frames < frames_cfg) begin
         send(CODE_ZERO, 1'b1);
         send(CODE_ZERO, 1'b1);
      end
      if (!aborted && $urandom_range(0, 3) == 0)
         send(BYTE_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // receiver: bursts of pops, random gaps, one long hold-off on request
   initial begin
      int gap_left;
      int burst_left;
      rsp_pop    = 1'b0;
      gap_left   = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (burst_left == 0 && gap_left == 0) begin
            gap_left   = pick_gap();
            burst_left = $urandom_range(1, 20);
         end
         if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            burst_left--;
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || (psel && penable)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int unsigned fs;
      int unsigned df;
      int          r;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_code_byte    = '0;
      req_stream_start = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      calm             = 1'b0;
      hold_rsp         = 1'b0;
      start_next       = 1'b0;
      beats_sent       = 0;
      frames_cfg       = DELTA_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset config has no frames: first code byte ends the stream
      start_next = 1'b1;
      send(8'h42, 1'b1);
      send(CODE_ZERO, 1'b0);

      // one-pixel frame, two frames: literals, fill, zero runs, flagged skip
      set_config(1, 2);
      start_next = 1'b1;
      send(8'h02, 1'b1);
      send(8'hFF, 1'b1);
      send(8'h00, 1'b1);
      send(CODE_ZERO, 1'b1);
      send(8'hFF, 1'b1);
      send(8'hAB, 1'b1);
      send_word(WORD_RUN);
      send(CODE_ZERO, 1'b1);
      send_word(16'hFFFF);
      send(8'h01, 1'b1);
      send(8'h5A, 1'b1);
      send_word(FRAME_END_WORD);
      send_word(16'h1234);
      send_word(FRAME_END_WORD);
      send(8'h77, 1'b0);

      // largest frame and frame count, stream ended by a zero pair
      set_config(FRAME_SIZE_MAX, 16'hFFFF);
      start_next = 1'b1;
      send(CODE_ZERO, 1'b1);
      send(CODE_ZERO, 1'b1);

      set_config(2000, 0);
      start_next = 1'b1;
      send(8'h3C, 1'b1);

      // receiver holds off while a long literal keeps coming
      set_config(64, 1);
      calm       = 1'b1;
      hold_rsp   = 1'b1;
      start_next = 1'b1;
      send(8'd40, 1'b1);
      repeat (40) send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      send_word(FRAME_END_WORD);
      calm = 1'b0;

      // skip until the cursor saturates, then a short literal
      set_config(FRAME_SIZE_MAX, 1);
      start_next = 1'b1;
      repeat (65) send_word(WORD_SKIP_MAX);
      send(8'h04, 1'b1);
      repeat (4) send(BYTE_W'($urandom_range(0, 255)), 1'b1);
      send_word(FRAME_END_WORD);

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0:       fs = 1;
               1:       fs = FRAME_SIZE_MAX;
               2:       fs = $urandom_range(1, 400);
               default: fs = $urandom_range(1, FRAME_SIZE_MAX);
            endcase
            r  = $urandom_range(0, 9);
            df = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(1, 4);
            set_config(fs, df);
         end
         calm = ($urandom_range(0, 4) == 0);
         send_stream();
      end
      calm = 1'b0;

      req_push <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
